[design/obg_pkg.sv]
// ============================================================================
// obg_pkg
// Shared types, widths and codes of the obstacle speed gate.
// ============================================================================
`default_nettype none

package obg_pkg;

    // Field widths
    localparam int SPEED_W    = 15;
    localparam int DIST_W     = 12;
    localparam int COEF_W     = 16;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Datapath widths of the shared multiplier and the braking-distance sum
    localparam int TERM_W     = SPEED_W + COEF_W;   // coefficient times magnitude
    localparam int PROD_W     = TERM_W + SPEED_W;   // widest product
    localparam int ACC_W      = PROD_W + 1;         // quadratic plus linear term
    localparam int LIN_SHIFT  = 12;
    localparam int FRAC_SHIFT = 24;
    localparam int WHOLE_W    = ACC_W - FRAC_SHIFT;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Action codes of an input transaction
    localparam logic [ACT_W-1:0] ACT_WANTED = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DRIVEN = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STOP   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SENSOR = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLEX_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_BRAKE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BRAKE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR      = 3'd5;

    // Configuration reset values
    localparam logic [DIST_W-1:0] FIXED_BRAKE_RST = 12'd300;
    localparam logic [DIST_W-1:0] IGNORE_RST      = 12'd90;
    localparam logic [DIST_W-1:0] MIN_BRAKE_RST   = 12'd100;

    // Operation codes of the shared multiply-accumulate unit
    localparam logic [1:0] MAC_LIN = 2'd0;  // acc = linear_coef * |s| << 12
    localparam logic [1:0] MAC_SQ  = 2'd1;  // term = square_coef * |s|
    localparam logic [1:0] MAC_SQ2 = 2'd2;  // acc = acc + term * |s|

    typedef struct packed {
        logic              flexible_mode;
        logic [DIST_W-1:0] fixed_brake_distance;
        logic [DIST_W-1:0] ignore_distance;
        logic [DIST_W-1:0] min_brake_distance;
        logic [COEF_W-1:0] square_coef;
        logic [COEF_W-1:0] linear_coef;
    } cfg_t;

    typedef struct packed {
        logic       en;
        logic [1:0] op;
    } mac_ctrl_t;

endpackage

`default_nettype wire

[design/obg_if.sv]
// ============================================================================
// obg_if
// Valid/ready channel interfaces: input items, results and configuration.
// ============================================================================
`default_nettype none

interface obg_in_if;
    logic                                valid;
    logic                                ready;
    logic [obg_pkg::ACT_W-1:0]           action;
    logic signed [obg_pkg::SPEED_W-1:0]  speed_value;
    logic                                stop_value;
    logic [obg_pkg::DIST_W-1:0]          front_left_in;
    logic [obg_pkg::DIST_W-1:0]          front_mid_in;
    logic [obg_pkg::DIST_W-1:0]          front_right_in;
    logic [obg_pkg::DIST_W-1:0]          rear_left_in;
    logic [obg_pkg::DIST_W-1:0]          rear_mid_in;
    logic [obg_pkg::DIST_W-1:0]          rear_right_in;

    modport source (
        output valid, action, speed_value, stop_value, front_left_in, front_mid_in,
               front_right_in, rear_left_in, rear_mid_in, rear_right_in,
        input  ready
    );
    modport sink (
        input  valid, action, speed_value, stop_value, front_left_in, front_mid_in,
               front_right_in, rear_left_in, rear_mid_in, rear_right_in,
        output ready
    );
endinterface

interface obg_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [obg_pkg::SPEED_W-1:0]  out_speed;
    logic                                blocked;

    modport source (output valid, out_speed, blocked, input ready);
    modport sink (input valid, out_speed, blocked, output ready);
endinterface

interface obg_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [obg_pkg::CFG_IDX_W-1:0]       index;
    logic [obg_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/obg_cfg_regs.sv]
// ============================================================================
// obg_cfg_regs
// Configuration register file, written through the configuration channel.
// ============================================================================
`default_nettype none

module obg_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    obg_cfg_if.sink       cfg_ch,
    output obg_pkg::cfg_t cfg
);
    import obg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    // Writes are always taken; unknown indexes are dropped.
    assign cfg_ch.ready = 1'b1;
    assign wr_en        = cfg_ch.valid;

    // Register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_ch.index)
                CFG_FLEX_MODE:   cfg_next.flexible_mode        = cfg_ch.data[0];
                CFG_FIXED_BRAKE: cfg_next.fixed_brake_distance = cfg_ch.data[DIST_W-1:0];
                CFG_IGNORE:      cfg_next.ignore_distance      = cfg_ch.data[DIST_W-1:0];
                CFG_MIN_BRAKE:   cfg_next.min_brake_distance   = cfg_ch.data[DIST_W-1:0];
                CFG_SQUARE:      cfg_next.square_coef          = cfg_ch.data[COEF_W-1:0];
                CFG_LINEAR:      cfg_next.linear_coef          = cfg_ch.data[COEF_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flexible_mode        <= 1'b1;
            cfg_reg.fixed_brake_distance <= FIXED_BRAKE_RST;
            cfg_reg.ignore_distance      <= IGNORE_RST;
            cfg_reg.min_brake_distance   <= MIN_BRAKE_RST;
            cfg_reg.square_coef          <= '0;
            cfg_reg.linear_coef          <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[design/obg_mac.sv]
// ============================================================================
// obg_mac
// Shared multiply-accumulate unit for the quadratic braking-distance sum.
// ============================================================================
`default_nettype none

module obg_mac (
    input  logic                          clk,
    input  obg_pkg::mac_ctrl_t            ctrl,
    input  logic [obg_pkg::SPEED_W-1:0]   mag,
    input  logic [obg_pkg::COEF_W-1:0]    square_coef,
    input  logic [obg_pkg::COEF_W-1:0]    linear_coef,
    output logic [obg_pkg::ACC_W-1:0]     acc
);
    import obg_pkg::*;

    logic [TERM_W-1:0] term_reg;
    logic [TERM_W-1:0] term_next;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [TERM_W-1:0] op_a;
    logic [PROD_W-1:0] prod;

    // Operand select for the single multiplier
    always_comb
    begin
        case (ctrl.op)
            MAC_LIN: op_a = TERM_W'(linear_coef);
            MAC_SQ:  op_a = TERM_W'(square_coef);
            MAC_SQ2: op_a = term_reg;
            default: op_a = '0;
        endcase
    end

    assign prod = PROD_W'(op_a) * PROD_W'(mag);

    // Accumulator and intermediate term update
    always_comb
    begin
        acc_next  = acc_reg;
        term_next = term_reg;
        if (ctrl.en)
        begin
            case (ctrl.op)
                MAC_LIN: acc_next  = ACC_W'(prod[TERM_W-1:0]) << LIN_SHIFT;
                MAC_SQ:  term_next = prod[TERM_W-1:0];
                MAC_SQ2: acc_next  = acc_reg + ACC_W'(prod);
                default: acc_next  = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        term_reg <= term_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

[design/obstacle_speed_gate_core.sv]
// ============================================================================
// obstacle_speed_gate_core
// Emergency-stop gate: passes a wanted speed or blocks it from sensor data.
// ============================================================================
// Usage:
// Input transactions on in_ch carry an action code. Driven-speed, stop-flag
// and sensor updates are stored when accepted and give no result. A
// wanted-speed transaction gives exactly one result on out_ch: the wanted
// speed with blocked low, or zero with blocked high.
// A wanted-speed item holds in_ch.ready low from acceptance until the
// sequencer has stepped one shared 31x15 multiplier through three products,
// then the saturating braking-distance add, then the sensor compare, and
// has loaded the result; update items are taken while the block is idle.
// The result sits in an output register, so new updates are accepted while
// it waits; when out_ch.ready stays low, a following wanted-speed item
// stops at its final step until the pending result is taken.
// The configuration channel is always ready and is to be written only while
// idle; the block itself does not enforce this. Reset restores the
// configuration defaults, clears the stop flag, the driven speed and all six
// distances, and empties the output register.
// ============================================================================
`default_nettype none

module obstacle_speed_gate_core (
    input  logic      clk,
    input  logic      rst_n,
    obg_in_if.sink    in_ch,
    obg_out_if.source out_ch,
    obg_cfg_if.sink   cfg_ch
);
    import obg_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LIN    = 3'd1;
    localparam logic [2:0] S_SQ     = 3'd2;
    localparam logic [2:0] S_SQ2    = 3'd3;
    localparam logic [2:0] S_BRAKE  = 3'd4;
    localparam logic [2:0] S_DECIDE = 3'd5;

    cfg_t       cfg;
    mac_ctrl_t  mac_ctrl;
    logic [ACC_W-1:0] mac_acc;

    logic [2:0] state_reg, state_next;

    // Held vehicle state
    logic                       stop_reg;
    logic signed [SPEED_W-1:0]  driven_reg;
    logic [DIST_W-1:0]          front_reg [3];
    logic [DIST_W-1:0]          rear_reg  [3];

    // Per-item working registers
    logic signed [SPEED_W-1:0]  wanted_reg;
    logic [SPEED_W-1:0]         mag_reg;
    logic                       use_front_reg;
    logic                       nogo_reg;
    logic [DIST_W-1:0]          brake_reg;

    // Output register
    logic                       out_valid_reg;
    logic signed [SPEED_W-1:0]  out_speed_reg;
    logic                       out_blocked_reg;

    logic                       in_acc;
    logic                       wanted_acc;
    logic signed [SPEED_W-1:0]  dir_speed;
    logic                       dir_front;
    logic                       dir_nogo;
    logic [SPEED_W-1:0]         dir_mag;
    logic [WHOLE_W:0]           brake_sum;
    logic [DIST_W-1:0]          brake_flex;
    logic [DIST_W-1:0]          sel_dist [3];
    logic                       all_above_ignore;
    logic                       all_above_brake;
    logic                       item_blocked;
    logic                       out_free;
    logic                       result_load;

    obg_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    obg_mac u_mac (
        .clk         (clk),
        .ctrl        (mac_ctrl),
        .mag         (mag_reg),
        .square_coef (cfg.square_coef),
        .linear_coef (cfg.linear_coef),
        .acc         (mac_acc)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign wanted_acc  = in_acc && (in_ch.action == ACT_WANTED);

    // Direction pick: driven speed unless standing, then the wanted speed.
    always_comb
    begin
        dir_nogo  = stop_reg;
        dir_front = 1'b1;
        dir_speed = driven_reg;
        if (driven_reg > 15'sd1)
        begin
            dir_front = 1'b1;
        end
        else if (driven_reg < -15'sd1)
        begin
            dir_front = 1'b0;
        end
        else
        begin
            dir_speed = in_ch.speed_value;
            if (in_ch.speed_value > 15'sd1)
                dir_front = 1'b1;
            else if (in_ch.speed_value < -15'sd1)
                dir_front = 1'b0;
            else
                dir_nogo = 1'b1;
        end
        dir_mag = dir_speed[SPEED_W-1] ? (~dir_speed + 15'd1) : dir_speed;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (wanted_acc) state_next = S_LIN;
            S_LIN:    state_next = S_SQ;
            S_SQ:     state_next = S_SQ2;
            S_SQ2:    state_next = S_BRAKE;
            S_BRAKE:  state_next = S_DECIDE;
            S_DECIDE: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Multiplier steps
    always_comb
    begin
        mac_ctrl.en = 1'b0;
        mac_ctrl.op = MAC_LIN;
        unique case (state_reg)
            S_LIN:
            begin
                mac_ctrl.en = 1'b1;
                mac_ctrl.op = MAC_LIN;
            end
            S_SQ:
            begin
                mac_ctrl.en = 1'b1;
                mac_ctrl.op = MAC_SQ;
            end
            S_SQ2:
            begin
                mac_ctrl.en = 1'b1;
                mac_ctrl.op = MAC_SQ2;
            end
            default:
            begin
                mac_ctrl.en = 1'b0;
                mac_ctrl.op = MAC_LIN;
            end
        endcase
    end

    // Saturating braking distance from the integer part of the sum
    assign brake_sum  = (WHOLE_W + 1)'(mac_acc[ACC_W-1:FRAC_SHIFT])
                      + (WHOLE_W + 1)'(cfg.min_brake_distance);
    assign brake_flex = (brake_sum > (WHOLE_W + 1)'(DIST_MAX)) ? DIST_MAX
                                                                : brake_sum[DIST_W-1:0];

    // Sensor rule on the picked side
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sel_dist[i] = use_front_reg ? front_reg[i] : rear_reg[i];
        end
        all_above_ignore = (sel_dist[0] > cfg.ignore_distance)
                        && (sel_dist[1] > cfg.ignore_distance)
                        && (sel_dist[2] > cfg.ignore_distance);
        all_above_brake  = (sel_dist[0] > brake_reg)
                        && (sel_dist[1] > brake_reg)
                        && (sel_dist[2] > brake_reg);
        item_blocked     = nogo_reg || (all_above_ignore && !all_above_brake);
    end

    assign out_free    = !out_valid_reg || out_ch.ready;
    assign result_load = (state_reg == S_DECIDE) && out_free;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            stop_reg      <= 1'b0;
            driven_reg    <= '0;
            for (int i = 0; i < 3; i++)
            begin
                front_reg[i] <= '0;
                rear_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (result_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (in_acc)
            begin
                case (in_ch.action)
                    ACT_DRIVEN: driven_reg <= in_ch.speed_value;
                    ACT_STOP:   stop_reg   <= in_ch.stop_value;
                    ACT_SENSOR:
                    begin
                        front_reg[0] <= in_ch.front_left_in;
                        front_reg[1] <= in_ch.front_mid_in;
                        front_reg[2] <= in_ch.front_right_in;
                        rear_reg[0]  <= in_ch.rear_left_in;
                        rear_reg[1]  <= in_ch.rear_mid_in;
                        rear_reg[2]  <= in_ch.rear_right_in;
                    end
                    default:
                    begin
                        stop_reg <= stop_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (wanted_acc)
        begin
            wanted_reg    <= in_ch.speed_value;
            mag_reg       <= dir_mag;
            use_front_reg <= dir_front;
            nogo_reg      <= dir_nogo;
        end
        if (state_reg == S_BRAKE)
        begin
            brake_reg <= cfg.flexible_mode ? brake_flex : cfg.fixed_brake_distance;
        end
        if (result_load)
        begin
            out_speed_reg   <= item_blocked ? '0 : wanted_reg;
            out_blocked_reg <= item_blocked;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_speed = out_speed_reg;
    assign out_ch.blocked   = out_blocked_reg;

    // A blocked result always carries a zero speed.
    a_blocked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.blocked |-> out_ch.out_speed == '0)
        else $error("blocked result with nonzero speed");

    // A wanted-speed item makes the block busy in the next cycle.
    a_busy_after_wanted: assert property (@(posedge clk) disable iff (!rst_n)
        wanted_acc |=> !in_ch.ready)
        else $error("input still ready after wanted-speed item");

    // A passed speed is never issued while the stop flag is set.
    a_stop_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        result_load && stop_reg |=> out_ch.blocked)
        else $error("result passed while stop flag set");

    // A result only leaves the final sequencer step.
    a_load_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DECIDE)
        else $error("result raised outside the decide step");

endmodule

`default_nettype wire

[verif/tb_obstacle_speed_gate_core.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_obstacle_speed_gate_core
// Drives update and wanted-speed transactions into the obstacle speed gate,
// takes each gate decision from the directed table or predicts it from a local
// model of the held state and the configuration, and compares every result field.
// A short table of directed rows comes first, then randomized phases under
// different configurations, idle patterns and a long output back-pressure.
// ============================================================================

module tb_obstacle_speed_gate_core;
    import obg_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 206;
    localparam int PHASE_COUNT    = 5;

    // Register indexes that map to no register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [ACT_W-1:0]          action;
        logic signed [SPEED_W-1:0] speed;
        logic                      stop;
        // Front left, mid, right, then rear left, mid, right.
        logic [5:0][DIST_W-1:0]    sonar;
    } gate_item_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic                      blocked;
    } verdict_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        gate_item_t            item;
        logic                  typed;
        verdict_t              verdict;
        logic [CFG_IDX_W-1:0]  cfg_index;
        logic [CFG_DATA_W-1:0] cfg_data;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    obg_in_if  in_ch();
    obg_out_if out_ch();
    obg_cfg_if cfg_ch();

    obstacle_speed_gate_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Local copy of the gate configuration and held vehicle state.
    cfg_t                      gate_cfg;
    logic                      held_stop_q;
    logic signed [SPEED_W-1:0] held_driven_q;
    logic [DIST_W-1:0]         front_q [3];
    logic [DIST_W-1:0]         rear_q [3];

    verdict_t    pending_verdicts [$];
    verdict_t    oldest_verdict;
    stim_row_t   directed_rows [$];

    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req       = 0;
    int unsigned hold_ack       = 0;
    int unsigned hold_left      = 0;
    int unsigned quiet_cycles   = 0;

    // Clock generation.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Braking distance for a speed under the current configuration.
    function automatic logic [DIST_W-1:0] brake_span(input logic signed [SPEED_W-1:0] s);
        logic [63:0] mag;
        logic [63:0] total;
        if (!gate_cfg.flexible_mode)
            return gate_cfg.fixed_brake_distance;
        mag   = (s < 0) ? -longint'(s) : longint'(s);
        total = gate_cfg.square_coef * mag * mag
              + ((gate_cfg.linear_coef * mag) << LIN_SHIFT);
        total = (total >> FRAC_SHIFT) + gate_cfg.min_brake_distance;
        return (total > DIST_MAX) ? DIST_MAX : total[DIST_W-1:0];
    endfunction

    // A side is clear unless all three readings are real and one is too close.
    function automatic logic side_clear(input logic [DIST_W-1:0] d [3],
                                        input logic [DIST_W-1:0] brake);
        logic all_real;
        all_real = d[0] > gate_cfg.ignore_distance && d[1] > gate_cfg.ignore_distance
                && d[2] > gate_cfg.ignore_distance;
        if (!all_real)
            return 1'b1;
        return d[0] > brake && d[1] > brake && d[2] > brake;
    endfunction

    // Decision for one wanted speed against the held state.
    function automatic verdict_t gate_verdict(input logic signed [SPEED_W-1:0] wanted);
        logic     ok;
        verdict_t v;
        if (held_stop_q)
            ok = 1'b0;
        else if (held_driven_q > 1)
            ok = side_clear(front_q, brake_span(held_driven_q));
        else if (held_driven_q < -1)
            ok = side_clear(rear_q, brake_span(held_driven_q));
        else if (wanted > 1)
            ok = side_clear(front_q, brake_span(wanted));
        else if (wanted < -1)
            ok = side_clear(rear_q, brake_span(wanted));
        else
            ok = 1'b0;
        v.speed   = ok ? wanted : '0;
        v.blocked = !ok;
        return v;
    endfunction

    // Apply one accepted transaction to the local state.
    task automatic track_item(input gate_item_t it, input logic typed, input verdict_t typed_v);
        case (it.action)
            ACT_WANTED: pending_verdicts.push_back(typed ? typed_v : gate_verdict(it.speed));
            ACT_DRIVEN: held_driven_q = it.speed;
            ACT_STOP:   held_stop_q = it.stop;
            default:
            begin
                front_q[0] = it.sonar[0];
                front_q[1] = it.sonar[1];
                front_q[2] = it.sonar[2];
                rear_q[0]  = it.sonar[3];
                rear_q[1]  = it.sonar[4];
                rear_q[2]  = it.sonar[5];
            end
        endcase
    endtask

    // Offer one transaction, with an optional random gap before it.
    task automatic send_item(input gate_item_t it, input logic typed, input verdict_t typed_v);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid          <= 1'b1;
        in_ch.action         <= it.action;
        in_ch.speed_value    <= it.speed;
        in_ch.stop_value     <= it.stop;
        in_ch.front_left_in  <= it.sonar[0];
        in_ch.front_mid_in   <= it.sonar[1];
        in_ch.front_right_in <= it.sonar[2];
        in_ch.rear_left_in   <= it.sonar[3];
        in_ch.rear_mid_in    <= it.sonar[4];
        in_ch.rear_right_in  <= it.sonar[5];
        do
            @(posedge clk);
        while (!in_ch.ready);
        track_item(it, typed, typed_v);
    endtask

    // Stop offering, wait for every pending result, then let the block go quiet.
    task automatic drain_and_settle();
        in_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write transaction.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_FLEX_MODE:   gate_cfg.flexible_mode        = data[0];
            CFG_FIXED_BRAKE: gate_cfg.fixed_brake_distance = data[DIST_W-1:0];
            CFG_IGNORE:      gate_cfg.ignore_distance      = data[DIST_W-1:0];
            CFG_MIN_BRAKE:   gate_cfg.min_brake_distance   = data[DIST_W-1:0];
            CFG_SQUARE:      gate_cfg.square_coef          = data;
            CFG_LINEAR:      gate_cfg.linear_coef          = data;
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Write a full register set; unused upper data bits carry noise.
    task automatic cfg_load(input cfg_t c);
        cfg_write(CFG_FLEX_MODE, {15'($urandom), c.flexible_mode});
        cfg_write(CFG_FIXED_BRAKE, {4'($urandom), c.fixed_brake_distance});
        cfg_write(CFG_IGNORE, {4'($urandom), c.ignore_distance});
        cfg_write(CFG_MIN_BRAKE, {4'($urandom), c.min_brake_distance});
        cfg_write(CFG_SQUARE, c.square_coef);
        cfg_write(CFG_LINEAR, c.linear_coef);
        cfg_write(CFG_UNUSED_LO, 16'($urandom));
        cfg_write(CFG_UNUSED_HI, 16'($urandom));
    endtask

    // Configuration for each random phase: moderate, all high, fixed, all zero, moderate.
    function automatic cfg_t pick_cfg(input int phase);
        cfg_t c;
        c.flexible_mode        = 1'b1;
        c.fixed_brake_distance = 12'($urandom_range(1500));
        c.ignore_distance      = 12'($urandom_range(200, 40));
        c.min_brake_distance   = 12'($urandom_range(300));
        c.square_coef          = 16'($urandom_range(400));
        c.linear_coef          = 16'($urandom_range(600));
        case (phase)
            1:       c = '1;
            2:       c.flexible_mode = 1'b0;
            3:       c = '0;
            default: ;
        endcase
        return c;
    endfunction

    // Speeds: mostly in range, some near standstill, some raw 15-bit values.
    function automatic logic signed [SPEED_W-1:0] rand_speed();
        int v;
        case ($urandom_range(9))
            0, 1, 2: v = int'($urandom_range(6)) - 3;
            8, 9:    v = $urandom;
            default: v = int'($urandom_range(20000)) - 10000;
        endcase
        return v[SPEED_W-1:0];
    endfunction

    // Distances clustered around the thresholds that decide the outcome.
    function automatic logic [DIST_W-1:0] rand_dist(input int pivot);
        int v;
        case ($urandom_range(4))
            0:       v = $urandom_range(4095);
            1:       v = int'(gate_cfg.ignore_distance) + int'($urandom_range(4)) - 2;
            2:       v = pivot + int'($urandom_range(80)) - 40;
            3:       v = $urandom_range(1) ? 4095 : 0;
            default: v = $urandom_range(1500);
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[DIST_W-1:0];
    endfunction

    function automatic gate_item_t rand_item();
        gate_item_t  it;
        int unsigned pick;
        int          pivot;
        pick = $urandom_range(99);
        if (pick < 45)
            it.action = ACT_WANTED;
        else if (pick < 60)
            it.action = ACT_DRIVEN;
        else if (pick < 70)
            it.action = ACT_STOP;
        else
            it.action = ACT_SENSOR;
        it.speed = rand_speed();
        // Driven speeds often sit at standstill so the wanted speed decides.
        if (it.action == ACT_DRIVEN && $urandom_range(1))
            it.speed = SPEED_W'(int'($urandom_range(6)) - 3);
        it.stop = ($urandom_range(99) < 40);
        pivot = brake_span(rand_speed());
        for (int i = 0; i < 6; i++)
            it.sonar[i] = rand_dist(pivot);
        return it;
    endfunction

    // Directed table builders.
    task automatic add_wanted(input int speed, input logic typed, input int exp_speed,
                              input logic exp_blocked);
        stim_row_t row;
        row                 = '0;
        row.kind            = ROW_ITEM;
        row.item.action     = ACT_WANTED;
        row.item.speed      = speed[SPEED_W-1:0];
        row.typed           = typed;
        row.verdict.speed   = exp_speed[SPEED_W-1:0];
        row.verdict.blocked = exp_blocked;
        directed_rows.push_back(row);
    endtask

    task automatic add_update(input logic [ACT_W-1:0] action, input int speed, input logic stop,
                              input int fl, input int fm, input int fr,
                              input int rl, input int rm, input int rr);
        stim_row_t row;
        row             = '0;
        row.kind        = ROW_ITEM;
        row.item.action = action;
        row.item.speed  = speed[SPEED_W-1:0];
        row.item.stop   = stop;
        row.item.sonar  = {rr[DIST_W-1:0], rm[DIST_W-1:0], rl[DIST_W-1:0],
                           fr[DIST_W-1:0], fm[DIST_W-1:0], fl[DIST_W-1:0]};
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input int data);
        stim_row_t row;
        row           = '0;
        row.kind      = ROW_CFG;
        row.cfg_index = idx;
        row.cfg_data  = data[CFG_DATA_W-1:0];
        directed_rows.push_back(row);
    endtask

    // Result receiver: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack     <= hold_req;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result transaction with the oldest predicted verdict.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual out_speed %0d blocked %0b",
                         $time, out_ch.out_speed, out_ch.blocked);
                mismatch_count++;
            end
            else
            begin
                oldest_verdict = pending_verdicts.pop_front();
                if (out_ch.out_speed !== oldest_verdict.speed)
                begin
                    $display("%0t: out_speed mismatch, expected %0d, actual %0d",
                             $time, oldest_verdict.speed, out_ch.out_speed);
                    mismatch_count++;
                end
                if (out_ch.blocked !== oldest_verdict.blocked)
                begin
                    $display("%0t: blocked mismatch, expected %0b, actual %0b",
                             $time, oldest_verdict.blocked, out_ch.blocked);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired after %0d quiet cycles", $time, quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Main sequence.
    initial
    begin : stimulus
        verdict_t none_v;
        int       phase;

        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.action         = ACT_WANTED;
        in_ch.speed_value    = '0;
        in_ch.stop_value     = 1'b0;
        in_ch.front_left_in  = '0;
        in_ch.front_mid_in   = '0;
        in_ch.front_right_in = '0;
        in_ch.rear_left_in   = '0;
        in_ch.rear_mid_in    = '0;
        in_ch.rear_right_in  = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_FLEX_MODE;
        cfg_ch.data          = '0;
        none_v               = '0;

        // State after reset.
        gate_cfg.flexible_mode        = 1'b1;
        gate_cfg.fixed_brake_distance = FIXED_BRAKE_RST;
        gate_cfg.ignore_distance      = IGNORE_RST;
        gate_cfg.min_brake_distance   = MIN_BRAKE_RST;
        gate_cfg.square_coef          = '0;
        gate_cfg.linear_coef          = '0;
        held_stop_q                   = 1'b0;
        held_driven_q                 = '0;
        for (int i = 0; i < 3; i++)
        begin
            front_q[i] = '0;
            rear_q[i]  = '0;
        end

        // Directed rows; reset defaults give a braking distance of 100.
        add_wanted(500, 1'b1, 500, 1'b0);       // all readings zero, ignored
        add_wanted(0, 1'b1, 0, 1'b1);           // standing, no direction
        add_wanted(1, 1'b1, 0, 1'b1);
        add_wanted(-1, 1'b1, 0, 1'b1);
        add_wanted(2, 1'b1, 2, 1'b0);
        add_update(ACT_SENSOR, 0, 1'b0, 95, 95, 95, 95, 95, 95);
        add_wanted(10000, 1'b1, 0, 1'b1);       // real readings inside brake range
        add_wanted(-10000, 1'b1, 0, 1'b1);
        add_update(ACT_SENSOR, 0, 1'b0, 4095, 4095, 4095, 0, 4095, 4095);
        add_wanted(300, 1'b1, 300, 1'b0);
        add_update(ACT_STOP, 0, 1'b1, 0, 0, 0, 0, 0, 0);
        add_wanted(300, 1'b1, 0, 1'b1);         // stop flag always blocks
        add_update(ACT_STOP, 0, 1'b0, 0, 0, 0, 0, 0, 0);
        add_update(ACT_DRIVEN, 500, 1'b0, 0, 0, 0, 0, 0, 0);
        add_wanted(-300, 1'b1, -300, 1'b0);     // driven speed picks the front
        add_update(ACT_DRIVEN, -16384, 1'b0, 0, 0, 0, 0, 0, 0);
        add_wanted(0, 1'b1, 0, 1'b0);
        add_update(ACT_DRIVEN, 1, 1'b0, 0, 0, 0, 0, 0, 0);
        add_wanted(16383, 1'b1, 16383, 1'b0);
        add_cfg(CFG_SQUARE, 65535);
        add_cfg(CFG_LINEAR, 65535);
        add_wanted(10000, 1'b1, 0, 1'b1);       // saturated braking distance
        // Noise in the unused stop and speed fields of a sensor update.
        add_update(ACT_SENSOR, -777, 1'b1, 4095, 4095, 90, 4095, 4095, 4095);
        add_wanted(10000, 1'b1, 10000, 1'b0);
        add_wanted(-10000, 1'b1, 0, 1'b1);
        add_cfg(CFG_FLEX_MODE, 0);
        add_cfg(CFG_FIXED_BRAKE, 4094);
        add_wanted(-10000, 1'b0, 0, 1'b0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                drain_and_settle();
                cfg_write(directed_rows[r].cfg_index, directed_rows[r].cfg_data);
            end
            else
                send_item(directed_rows[r].item, directed_rows[r].typed,
                          directed_rows[r].verdict);
        end

        // Random phases, each under its own configuration and idle pattern.
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_and_settle();
            cfg_load(pick_cfg(phase));
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 87; end
                3:       begin send_idle_pct = 29; recv_stall_pct = 29; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            // Last phase: hold results back long enough to fill the block.
            if (phase == PHASE_COUNT - 1)
                hold_req <= hold_req + 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(rand_item(), 1'b0, none_v);
        end

        drain_and_settle();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
design/obg_pkg.sv
design/obg_if.sv
design/obg_cfg_regs.sv
design/obg_mac.sv
design/obstacle_speed_gate_core.sv
verif/tb_obstacle_speed_gate_core.sv
